FILE: rtl/direct_mapped_read_cache_defines.svh
// Assertion macros of the cache RTL, used by its top level.
`ifndef DIRECT_MAPPED_READ_CACHE_DEFINES_SVH
`define DIRECT_MAPPED_READ_CACHE_DEFINES_SVH

// Checked on every rising clk edge while arst_n is high.
`define DMRC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising clk edge, also during reset.
`define DMRC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/dmrc_pkg.sv
// Types and constants of the direct-mapped read cache.
`timescale 1ns / 1ps
package dmrc_pkg;

	localparam int ADDR_W = 12;
	localparam int DATA_W = 8;
	localparam int CNT_W  = 32;
	localparam int PEN_W  = 8;

	localparam logic [PEN_W-1:0] MISS_PENALTY_RST = 8'd10;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} dmrc_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] rdata;
		logic              hit;
		logic [CNT_W-1:0]  miss_count;
		logic [CNT_W-1:0]  elapsed_time;
	} dmrc_rsp_t;

	// Completion of a read, as seen by the statistics counters.
	typedef struct packed {
		logic read_done;
		logic miss;
	} dmrc_evt_t;

endpackage

FILE: rtl/direct_mapped_read_cache.sv
// Top level of the direct-mapped read cache.
// A request is taken on a rising clk edge with start high and busy low. A load
// request (req_type 0) writes one byte of backing memory; a read request looks
// up the line selected by the address and, on a miss, refills the whole line
// from backing memory before answering. Loads never touch cached lines.
// Each request yields one response on rsp, valid for the single cycle in which
// done is high; the receiver cannot stall it. rsp carries the byte, the hit
// flag and the saturating miss and elapsed-time counters after the request.
// Occupancy: a load answers in the cycle after it is taken and leaves busy low.
// A read hit registers its tag and data memory reads as it is taken, compares
// them in S_LOOKUP and answers. A read miss goes on to S_FILL, which refills
// the line one byte per cycle through the single port of backing memory and
// answers at its end. busy falls as done rises, so the next request may be
// taken while a response is shown. miss_penalty is written through cfg_we and
// cfg_wdata; the user must write it only while idle, as the block does not
// enforce this. Reset clears all line valid bits and both counters, sets
// miss_penalty to 10 and leaves backing memory, tags and line data undefined.
`timescale 1ns / 1ps
`include "direct_mapped_read_cache_defines.svh"
module direct_mapped_read_cache import dmrc_pkg::*; #(
	parameter int NUM_LINES  = 8,
	parameter int LINE_BYTES = 16,
	parameter int MEM_BYTES  = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  dmrc_req_t        req,
	output logic             done,
	output dmrc_rsp_t        rsp,
	input  logic             cfg_we,
	input  logic [PEN_W-1:0] cfg_wdata
);

	localparam int WORD_W = $clog2(LINE_BYTES);
	localparam int LINE_W = $clog2(NUM_LINES);
	localparam int MEM_AW = $clog2(MEM_BYTES);
	localparam int EA_W   = (MEM_AW < ADDR_W) ? MEM_AW : ADDR_W;
	localparam int TAG_W  = (EA_W > WORD_W + LINE_W) ? EA_W - WORD_W - LINE_W : 1;
	localparam int FULL_W = WORD_W + LINE_W + TAG_W;
	localparam int BLK_W  = LINE_W + TAG_W;
	localparam int CNT_FW = WORD_W + 1;
	localparam int DMEM_D = NUM_LINES * LINE_BYTES;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_FILL
	} state_t;

	state_t state_q;

	logic [PEN_W-1:0]     penalty_q;
	logic [NUM_LINES-1:0] valid_q;
	logic [LINE_W-1:0]    line_q;
	logic [WORD_W-1:0]    word_q;
	logic [TAG_W-1:0]     tag_q;
	logic [BLK_W-1:0]     blk_q;
	logic [CNT_FW-1:0]    fill_cnt_q;
	logic [DATA_W-1:0]    byte_q;
	logic                 done_q;
	logic [DATA_W-1:0]    rdata_q;
	logic                 hit_q;

	logic [DATA_W-1:0] back_mem [MEM_BYTES];
	logic [DATA_W-1:0] data_mem [DMEM_D];
	logic [TAG_W-1:0]  tag_mem  [NUM_LINES];
	logic [DATA_W-1:0] back_rd_q;
	logic [DATA_W-1:0] data_rd_q;
	logic [TAG_W-1:0]  tag_rd_q;

	logic [FULL_W-1:0]          in_ext;
	logic [LINE_W-1:0]          in_line;
	logic [WORD_W-1:0]          in_word;
	logic                       accept;
	logic                       lookup_hit;
	logic                       fill_last;
	logic [WORD_W-1:0]          wr_idx;
	logic                       back_we;
	logic                       back_re;
	logic [MEM_AW-1:0]          back_addr;
	logic [LINE_W+WORD_W-1:0]   data_addr;
	logic                       data_we;
	logic                       data_re;
	dmrc_evt_t                  evt;
	logic [CNT_W-1:0]           miss_count;
	logic [CNT_W-1:0]           elapsed_time;

	assign accept  = start && (state_q == S_IDLE);
	assign in_ext  = FULL_W'(req.addr[EA_W-1:0]);
	assign in_line = in_ext[WORD_W +: LINE_W];
	assign in_word = in_ext[WORD_W-1:0];

	assign lookup_hit = valid_q[line_q] && (tag_rd_q == tag_q);
	assign fill_last  = (fill_cnt_q == CNT_FW'(LINE_BYTES));
	assign wr_idx     = WORD_W'(fill_cnt_q - CNT_FW'(1));

	// Backing memory has one port: loads write it, refills read it.
	assign back_we = accept && (req.req_type == REQ_LOAD);
	assign back_re = ((state_q == S_LOOKUP) && !lookup_hit) ||
		((state_q == S_FILL) && !fill_last);

	always_comb begin
		unique case (state_q)
			S_IDLE:   back_addr = MEM_AW'(in_ext);
			S_LOOKUP: back_addr = MEM_AW'({blk_q, {WORD_W{1'b0}}});
			S_FILL:   back_addr = MEM_AW'({blk_q, fill_cnt_q[WORD_W-1:0]});
			default:  back_addr = MEM_AW'(in_ext);
		endcase
	end

	always_ff @(posedge clk) begin
		if (back_we) begin
			back_mem[back_addr] <= req.wdata;
		end
		if (back_re) begin
			back_rd_q <= back_mem[back_addr];
		end
	end

	// Line data: read when a read request is taken, written during the refill.
	assign data_we   = (state_q == S_FILL);
	assign data_re   = accept && (req.req_type == REQ_READ);
	assign data_addr = data_we ? {line_q, wr_idx} : {in_line, in_word};

	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[data_addr] <= back_rd_q;
		end else if (data_re) begin
			data_rd_q <= data_mem[data_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (data_we && fill_last) begin
			tag_mem[line_q] <= tag_q;
		end else if (data_re) begin
			tag_rd_q <= tag_mem[in_line];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			penalty_q <= MISS_PENALTY_RST;
		end else if (cfg_we) begin
			penalty_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			valid_q    <= '0;
			done_q     <= 1'b0;
			hit_q      <= 1'b0;
			rdata_q    <= '0;
			fill_cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						line_q <= in_line;
						word_q <= in_word;
						tag_q  <= in_ext[WORD_W+LINE_W +: TAG_W];
						blk_q  <= in_ext[FULL_W-1:WORD_W];
						if (req.req_type == REQ_LOAD) begin
							done_q  <= 1'b1;
							hit_q   <= 1'b0;
							rdata_q <= '0;
						end else begin
							state_q <= S_LOOKUP;
						end
					end
				end
				S_LOOKUP: begin
					if (lookup_hit) begin
						done_q  <= 1'b1;
						hit_q   <= 1'b1;
						rdata_q <= data_rd_q;
						state_q <= S_IDLE;
					end else begin
						fill_cnt_q <= CNT_FW'(1);
						state_q    <= S_FILL;
					end
				end
				S_FILL: begin
					if (wr_idx == word_q) begin
						byte_q <= back_rd_q;
					end
					if (fill_last) begin
						valid_q[line_q] <= 1'b1;
						done_q          <= 1'b1;
						hit_q           <= 1'b0;
						rdata_q         <= (wr_idx == word_q) ? back_rd_q : byte_q;
						state_q         <= S_IDLE;
					end else begin
						fill_cnt_q <= fill_cnt_q + CNT_FW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		evt.read_done = ((state_q == S_LOOKUP) && lookup_hit) ||
			((state_q == S_FILL) && fill_last);
		evt.miss      = (state_q == S_FILL) && fill_last;
	end

	dmrc_stats u_stats (
		.clk          (clk),
		.arst_n       (arst_n),
		.evt          (evt),
		.penalty      (penalty_q),
		.miss_count   (miss_count),
		.elapsed_time (elapsed_time)
	);

	assign busy             = (state_q != S_IDLE);
	assign done             = done_q;
	assign rsp.rdata        = rdata_q;
	assign rsp.hit          = hit_q;
	assign rsp.miss_count   = miss_count;
	assign rsp.elapsed_time = elapsed_time;

	// A response is only shown while the block is idle.
	`DMRC_ASSERT_ALWAYS(a_done_not_busy, done |-> !busy, "response shown while busy")
	// A hit must leave the miss counter untouched.
	`DMRC_ASSERT(a_hit_keeps_misses, (done && rsp.hit) |-> (miss_count == $past(miss_count)),
		"miss counter moved on a hit")
	// Every miss also counts as at least one time unit.
	`DMRC_ASSERT(a_time_covers_misses, elapsed_time >= miss_count,
		"elapsed time below miss count")

endmodule

FILE: rtl/dmrc_stats.sv
// Saturating miss and elapsed-time counters of the cache.
`timescale 1ns / 1ps
module dmrc_stats import dmrc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dmrc_evt_t        evt,
	input  logic [PEN_W-1:0] penalty,
	output logic [CNT_W-1:0] miss_count,
	output logic [CNT_W-1:0] elapsed_time
);

	logic [CNT_W-1:0] misses_q;
	logic [CNT_W-1:0] time_q;
	logic [CNT_W:0]   time_sum;
	logic [PEN_W-1:0] pen_add;

	// Adding 1 and the penalty in one step saturates the same way as two steps.
	assign pen_add  = evt.miss ? penalty : '0;
	assign time_sum = {1'b0, time_q} + (CNT_W+1)'(pen_add) + (CNT_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			misses_q <= '0;
			time_q   <= '0;
		end else if (evt.read_done) begin
			time_q <= time_sum[CNT_W] ? '1 : time_sum[CNT_W-1:0];
			if (evt.miss && misses_q != '1) begin
				misses_q <= misses_q + CNT_W'(1);
			end
		end
	end

	assign miss_count   = misses_q;
	assign elapsed_time = time_q;

endmodule
